/* src/ole_pkg.sv */
// shared types, constants and helpers of the ordered list engine
package ole_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 8;
	localparam int OUT_W    = 5;
	localparam int IW       = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int CMPW     = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic [2:0] {
		CMD_ADD_FRONT = 3'd0,
		CMD_ADD_BACK  = 3'd1,
		CMD_ADD_AT    = 3'd2,
		CMD_REM_FRONT = 3'd3,
		CMD_REM_BACK  = 3'd4,
		CMD_REM_AT    = 3'd5,
		CMD_GET_AT    = 3'd6,
		CMD_FIND      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_REM  = 2'd2
	} op_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		op_t             op;
		logic [IW-1:0]   slot;
		logic [VAL_W-1:0] value;
	} ole_ctrl_t;

	// decoded command
	typedef struct packed {
		ole_ctrl_t ctrl;
		status_t   status;
		logic      rd;
		logic      fnd;
	} ole_dec_t;

	// fit a count-wide value into the output field width
	function automatic logic [OUT_W-1:0] to_out(input logic [CW-1:0] x);
		logic [CW+OUT_W-1:0] t;
		t = {{OUT_W{1'b0}}, x};
		return t[OUT_W-1:0];
	endfunction

endpackage

/* src/ole_cell.sv */
// one list slot: holds a value, shifts with its neighbors, matches on find
module ole_cell import ole_pkg::*; (
	input  logic             clk,
	input  logic [IW-1:0]    idx,
	input  ole_ctrl_t        ctrl,
	input  logic [VAL_W-1:0] left_value,
	input  logic [VAL_W-1:0] right_value,
	input  logic             in_use,
	input  logic [VAL_W-1:0] search_value,
	input  logic             prior_hit_in,
	output logic             prior_hit_out,
	output logic             first_hit,
	output logic [VAL_W-1:0] value,
	output logic [VAL_W-1:0] sel_value
);

	logic [VAL_W-1:0] value_q;
	logic             match;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INS: begin
				if (idx > ctrl.slot) value_q <= left_value;
				else if (idx == ctrl.slot) value_q <= ctrl.value;
			end
			OP_REM: begin
				if (idx >= ctrl.slot) value_q <= right_value;
			end
			default: ;
		endcase
	end

	assign match         = in_use && (value_q == search_value);
	assign first_hit     = match && !prior_hit_in;
	assign prior_hit_out = prior_hit_in || match;
	assign value         = value_q;
	assign sel_value     = (idx == ctrl.slot) ? value_q : '0;

endmodule

/* src/ole_decode.sv */
// command decode: range and full checks, target slot, shift direction
module ole_decode import ole_pkg::*; (
	input  logic [2:0]       command,
	input  logic [VAL_W-1:0] item_value,
	input  logic [POS_W-1:0] position,
	input  logic [CW-1:0]    count,
	output ole_dec_t         dec
);

	logic [CMPW-1:0] posx;
	logic [CMPW-1:0] cntx;
	logic [CMPW-1:0] slotx;
	logic            full;
	logic            empty;
	logic            pos_bad_ins;
	logic            pos_bad_rd;

	assign posx        = {{(CMPW-POS_W){1'b0}}, position};
	assign cntx        = {{(CMPW-CW){1'b0}}, count};
	assign full        = (cntx >= CMPW'(CAPACITY));
	assign empty       = (count == '0);
	assign pos_bad_ins = (posx == '0) || (posx > cntx + CMPW'(1));
	assign pos_bad_rd  = (posx == '0) || (posx > cntx);

	always_comb begin
		dec            = '0;
		dec.ctrl.op    = OP_HOLD;
		dec.ctrl.value = item_value;
		dec.status     = ST_OK;
		slotx          = '0;
		unique case (cmd_t'(command))
			CMD_ADD_FRONT: begin
				if (full) dec.status = ST_FULL;
				else dec.ctrl.op = OP_INS;
			end
			CMD_ADD_BACK: begin
				slotx = cntx;
				if (full) dec.status = ST_FULL;
				else dec.ctrl.op = OP_INS;
			end
			CMD_ADD_AT: begin
				slotx = posx - CMPW'(1);
				if (full) dec.status = ST_FULL;
				else if (pos_bad_ins) dec.status = ST_MISS;
				else dec.ctrl.op = OP_INS;
			end
			CMD_REM_FRONT: begin
				if (empty) dec.status = ST_MISS;
				else begin
					dec.ctrl.op = OP_REM;
					dec.rd      = 1'b1;
				end
			end
			CMD_REM_BACK: begin
				slotx = cntx - CMPW'(1);
				if (empty) dec.status = ST_MISS;
				else begin
					dec.ctrl.op = OP_REM;
					dec.rd      = 1'b1;
				end
			end
			CMD_REM_AT: begin
				slotx = posx - CMPW'(1);
				if (pos_bad_rd) dec.status = ST_MISS;
				else begin
					dec.ctrl.op = OP_REM;
					dec.rd      = 1'b1;
				end
			end
			CMD_GET_AT: begin
				slotx = posx - CMPW'(1);
				if (pos_bad_rd) dec.status = ST_MISS;
				else dec.rd = 1'b1;
			end
			CMD_FIND: begin
				dec.fnd = 1'b1;
			end
			default: dec.status = ST_MISS;
		endcase
		dec.ctrl.slot = slotx[IW-1:0];
	end

endmodule

/* src/ordered_list_engine_core.sv */
// top level of the ordered list engine: decode, chain of list cells, result register
// a result beat is valid in the cycle after its command beat is accepted
// throughput: one command per cycle while in_stall is low; for every command
//   all cells shift or compare in parallel
// a new command is taken while the result register is empty or being drained
// reset: arst_n clears the entry count and the result valid; cell contents are not cleared
module ordered_list_engine_core import ole_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              command,
	input  logic signed [VAL_W-1:0] item_value,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] result_value,
	output logic [OUT_W-1:0]        found_position,
	output logic [OUT_W-1:0]        entry_count
);

	// entry count and result register
	logic [CW-1:0]    count_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [VAL_W-1:0] result_value_q;
	logic [OUT_W-1:0] found_position_q;
	logic [OUT_W-1:0] entry_count_q;

	ole_dec_t  dec;
	ole_ctrl_t cell_ctrl;
	logic      accept;

	logic [VAL_W-1:0] cell_val [CAPACITY];
	logic [VAL_W-1:0] cell_sel [CAPACITY];
	logic             first_hit [CAPACITY];
	logic             hit_chain [CAPACITY+1];

	logic [VAL_W-1:0] rd_value;
	logic [CW-1:0]    hit_pos;
	logic             any_hit;
	status_t          fin_status;
	logic [VAL_W-1:0] fin_value;
	logic [CW-1:0]    next_count;

	// the result register frees up in the same cycle it is drained
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	ole_decode u_decode (
		.command    (command),
		.item_value (item_value),
		.position   (position),
		.count      (count_q),
		.dec        (dec)
	);

	// cells only move on an accepted beat
	always_comb begin
		cell_ctrl = dec.ctrl;
		if (!accept) cell_ctrl.op = OP_HOLD;
	end

	assign hit_chain[0] = 1'b0;

	// cell i holds list position i+1; inserts shift toward the back,
	// removes pull from the back neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = dec.ctrl.value;
		end else begin : g_mid
			assign left_v = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_inner
			assign right_v = cell_val[i+1];
		end

		ole_cell u_cell (
			.clk           (clk),
			.idx           (IW'(i)),
			.ctrl          (cell_ctrl),
			.left_value    (left_v),
			.right_value   (right_v),
			.in_use        (CW'(i) < count_q),
			.search_value  (item_value),
			.prior_hit_in  (hit_chain[i]),
			.prior_hit_out (hit_chain[i+1]),
			.first_hit     (first_hit[i]),
			.value         (cell_val[i]),
			.sel_value     (cell_sel[i])
		);
	end

	// one-hot gathers: only the addressed cell and the first matching cell contribute
	always_comb begin
		rd_value = '0;
		hit_pos  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_value = rd_value | cell_sel[i];
			hit_pos  = hit_pos | ({CW{first_hit[i]}} & CW'(i + 1));
		end
	end

	assign any_hit = hit_chain[CAPACITY];

	// final status and value of the beat
	always_comb begin
		fin_status = dec.status;
		fin_value  = '0;
		if (dec.fnd) begin
			fin_status = any_hit ? ST_OK : ST_MISS;
			fin_value  = item_value;
		end else if (dec.rd) begin
			fin_value = rd_value;
		end
		if (fin_status != ST_OK) fin_value = '1;
	end

	always_comb begin
		next_count = count_q;
		case (dec.ctrl.op)
			OP_INS:  next_count = count_q + CW'(1);
			OP_REM:  next_count = count_q - CW'(1);
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= next_count;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q         <= fin_status;
			result_value_q   <= fin_value;
			found_position_q <= dec.fnd ? to_out(hit_pos) : '0;
			entry_count_q    <= to_out(next_count);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_value   = result_value_q;
	assign found_position = found_position_q;
	assign entry_count    = entry_count_q;

endmodule

/* src/ole_checker.sv */
// port-level checks of the ordered list engine and their binding
module ole_checker import ole_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [1:0]              status,
	input logic signed [VAL_W-1:0] result_value,
	input logic [OUT_W-1:0]        found_position,
	input logic [OUT_W-1:0]        entry_count
);

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// every accepted command beat yields a result beat next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted command produced no result beat");

	// a rejected command reports minus one
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> result_value == -32'sd1)
		else $error("failed command did not report minus one");

	// a full rejection only happens at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> entry_count == OUT_W'(CAPACITY))
		else $error("full status below capacity");

	// a found position is only reported on success
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (found_position != '0) |-> status == ST_OK)
		else $error("found position with failing status");

endmodule

bind ordered_list_engine_core ole_checker u_ole_checker (.*);

/* bench/tb.sv */
// testbench for the ordered list engine: random and directed commands checked against a list model
`timescale 1ns / 100ps

module tb import ole_pkg::*;;

	// one command beat as presented on the input channel
	typedef struct {
		cmd_t                    cmd;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        pos;
	} list_cmd_t;

	// one result beat as the list should report it
	typedef struct {
		cmd_t                    cmd;
		status_t                 status;
		logic signed [VAL_W-1:0] value;
		logic [OUT_W-1:0]        fpos;
		logic [OUT_W-1:0]        count;
	} list_reply_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CMDS = 550;
	localparam int SETTLE_CYCLES = 8;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [2:0]              command = CMD_ADD_FRONT;
	logic signed [VAL_W-1:0] item_value = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] result_value;
	logic [OUT_W-1:0]        found_position;
	logic [OUT_W-1:0]        entry_count;

	// commands waiting to be driven, the model's copy of the list,
	// and the results still owed by the block, oldest first
	list_cmd_t               pending_q[$];
	logic signed [VAL_W-1:0] list_model[$];
	list_reply_t             reply_q[$];

	list_cmd_t on_wire;
	int        total_cmds = 0;
	int        sent_cnt = 0;
	int        got_cnt = 0;
	int        mismatch_cnt = 0;
	int        cycle_cnt = 0;

	ordered_list_engine_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.item_value     (item_value),
		.position       (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.result_value   (result_value),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	// 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// a break in roughly 22 draws in a hundred, except for a calm stretch of
	// beats in the middle of the run where the side never idles
	function automatic bit take_break(input int done);
		if (done >= 250 && done < 400)
			return 1'b0;
		return $urandom_range(99) < 22;
	endfunction

	// apply one accepted command to the list model and queue the result it owes
	task automatic predict_list_op(input list_cmd_t c);
		list_reply_t r;
		int          n;
		int          p;
		bit          full;
		n = list_model.size();
		p = int'(c.pos);
		full = n >= CAPACITY;
		r.cmd = c.cmd;
		r.status = ST_OK;
		r.value = '0;
		r.fpos = '0;
		case (c.cmd)
			CMD_ADD_FRONT: begin
				if (full) r.status = ST_FULL;
				else list_model.push_front(c.value);
			end
			CMD_ADD_BACK: begin
				if (full) r.status = ST_FULL;
				else list_model.push_back(c.value);
			end
			CMD_ADD_AT: begin
				// fullness wins over a bad position
				if (full) r.status = ST_FULL;
				else if (p == 0 || p > n + 1) r.status = ST_MISS;
				else list_model.insert(p - 1, c.value);
			end
			CMD_REM_FRONT: begin
				if (n == 0) r.status = ST_MISS;
				else r.value = list_model.pop_front();
			end
			CMD_REM_BACK: begin
				if (n == 0) r.status = ST_MISS;
				else r.value = list_model.pop_back();
			end
			CMD_REM_AT: begin
				if (p == 0 || p > n) r.status = ST_MISS;
				else begin
					r.value = list_model[p - 1];
					list_model.delete(p - 1);
				end
			end
			CMD_GET_AT: begin
				if (p == 0 || p > n) r.status = ST_MISS;
				else r.value = list_model[p - 1];
			end
			default: begin
				// find: first match wins
				r.status = ST_MISS;
				for (int i = 0; i < n; i++) begin
					if (list_model[i] == c.value) begin
						r.status = ST_OK;
						r.fpos = OUT_W'(i + 1);
						r.value = c.value;
						break;
					end
				end
			end
		endcase
		if (r.status != ST_OK)
			r.value = -1;
		r.count = OUT_W'(list_model.size());
		reply_q.push_back(r);
	endtask

	task automatic queue_cmd(input cmd_t c, input logic signed [VAL_W-1:0] v, input int p);
		list_cmd_t x;
		x.cmd = c;
		x.value = v;
		x.pos = POS_W'(p);
		pending_q.push_back(x);
		total_cmds++;
	endtask

	// values mostly from a small set so that finds hit, the rest fully random
	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(99) < 30)
			return $urandom;
		case ($urandom_range(7))
			0: return 0;
			1: return 1;
			2: return -1;
			3: return 7;
			4: return 42;
			5: return 32'sh8000_0000;
			6: return 32'sh7fff_ffff;
			default: return 1000;
		endcase
	endfunction

	// add_pct steers the list toward full or toward empty
	function automatic list_cmd_t random_cmd(input int add_pct);
		list_cmd_t x;
		int        roll;
		if ($urandom_range(99) < add_pct)
			x.cmd = cmd_t'($urandom_range(2, 0));
		else
			x.cmd = cmd_t'($urandom_range(7, 3));
		x.value = pick_value();
		roll = $urandom_range(99);
		// positions mostly within or just past the list, some zero or far out
		if (roll < 80) x.pos = POS_W'($urandom_range(CAPACITY + 1, 1));
		else if (roll < 90) x.pos = '0;
		else x.pos = POS_W'($urandom_range(255));
		return x;
	endfunction

	// driver: the model sees a command on the edge it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_ADD_FRONT;
			item_value <= '0;
			position <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_list_op(on_wire);
				sent_cnt++;
			end
			// payload only moves once the current beat is gone
			if (!in_valid || !in_stall) begin
				if (pending_q.size() != 0 && !take_break(sent_cnt)) begin
					on_wire = pending_q.pop_front();
					in_valid <= 1'b1;
					command <= on_wire.cmd;
					item_value <= on_wire.value;
					position <= on_wire.pos;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: every accepted result is matched with the oldest owed result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got_cnt++;
				if (reply_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result beat: status %0d value %0d pos %0d count %0d",
							status, result_value, found_position, entry_count);
				end else begin
					list_reply_t e;
					e = reply_q.pop_front();
					if (status !== e.status || result_value !== e.value ||
							found_position !== e.fpos || entry_count !== e.count) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("%s: expected status %0d value %0d pos %0d count %0d, got %0d %0d %0d %0d",
								e.cmd.name(), e.status, e.value, e.fpos, e.count,
								status, result_value, found_position, entry_count);
					end
				end
			end
			out_stall <= take_break(got_cnt);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		int c;
		int add_pct;
		list_cmd_t x;

		// empty list: removal, read and find all miss
		queue_cmd(CMD_REM_FRONT, 0, 0);
		queue_cmd(CMD_GET_AT, 0, 1);
		queue_cmd(CMD_FIND, 0, 0);
		// bad insert positions: zero, and past count plus one
		queue_cmd(CMD_ADD_AT, 5, 0);
		queue_cmd(CMD_ADD_AT, 5, 2);
		// value extremes, add at count plus one lands at the back
		queue_cmd(CMD_ADD_AT, 32'sh7fff_ffff, 1);
		queue_cmd(CMD_ADD_FRONT, 32'sh8000_0000, 0);
		queue_cmd(CMD_ADD_BACK, 0, 0);
		queue_cmd(CMD_ADD_AT, -1, 4);
		// fill up to capacity through front, back and middle inserts
		for (int i = 0; i < CAPACITY - 4; i++) begin
			c = 4 + i;
			case (i % 3)
				0: queue_cmd(CMD_ADD_AT, 32'sh5a5a_0000 + i, 1);
				1: queue_cmd(CMD_ADD_AT, 32'sha5a5_0000 + i, c + 1);
				default: queue_cmd(CMD_ADD_AT, 32'sh0f0f_0000 + i, c / 2 + 1);
			endcase
		end
		// full list: inserts rejected, full checked before a bad position
		queue_cmd(CMD_ADD_FRONT, 9, 0);
		queue_cmd(CMD_ADD_AT, 9, 0);
		queue_cmd(CMD_FIND, -1, 0);
		queue_cmd(CMD_FIND, 12345, 0);
		queue_cmd(CMD_GET_AT, 0, 0);
		queue_cmd(CMD_REM_AT, 0, 255);
		queue_cmd(CMD_REM_AT, 0, CAPACITY);
		queue_cmd(CMD_REM_BACK, 0, 0);

		// random phases alternate between filling and draining
		for (int k = 0; k < RANDOM_CMDS; k++) begin
			case ((k / 50) % 4)
				0: add_pct = 85;
				1: add_pct = 30;
				2: add_pct = 60;
				default: add_pct = 15;
			endcase
			x = random_cmd(add_pct);
			pending_q.push_back(x);
			total_cmds++;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (!(sent_cnt == total_cmds && reply_q.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0 && reply_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
src/ole_pkg.sv
src/ole_cell.sv
src/ole_decode.sv
src/ordered_list_engine_core.sv
src/ole_checker.sv
bench/tb.sv
